// File: rtl/ppsd_pkg.sv
// Shared types, codes and feature lookup for the packed pattern stream decoder.
`default_nettype none
package ppsd_pkg;

  // Input commands
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_NEW  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_NOTE   = 2'd0;
  localparam logic [1:0] KIND_EFFECT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN   = 2'd1;
  localparam logic [1:0] STAT_MANY_FX   = 2'd2;
  localparam logic [1:0] STAT_TRUNCATED = 2'd3;

  // Limits
  localparam logic [8:0] MAX_ROWS    = 9'd256;
  localparam logic [8:0] ROWS_WIDE   = 9'd64;
  localparam logic [2:0] MAX_EFFECTS = 3'd4;

  // Feature mask bit positions
  localparam int MASK_W        = 50;
  localparam int FEAT_NO_NOTE  = 6;
  localparam int FEAT_NO_INST  = 7;
  localparam int FEAT_UNKNOWN  = 8;
  localparam int FEAT_SLOT3    = 46;
  localparam int FEAT_SLOT4    = 47;
  localparam int FEAT_ROWS64   = 48;
  localparam int FEAT_ROWS256  = 49;

  // Effect codes with special handling
  localparam logic [4:0] FX_EXT        = 5'd14;
  localparam logic [4:0] FX_NIBBLE_SEL = 5'h1e;
  localparam logic [4:0] FX_LAST       = 5'h1f;

  localparam logic [5:0] EXT_FEATURE [16] = '{
    6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd29, 6'd30, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34
  };

  // Queue depth in groups
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [8:0]        row;
    logic [4:0]        track;
    logic [7:0]        note;
    logic [7:0]        inst;
    logic [1:0]        slot;
    logic [4:0]        code;
    logic [7:0]        param;
    logic [1:0]        status;
    logic [MASK_W-1:0] mask;
    logic              last;
  } ppsd_res_t;

  // Results caused by one input item: one or two
  typedef struct packed {
    logic      two;
    ppsd_res_t r0;
    ppsd_res_t r1;
  } ppsd_grp_t;

  // Feature bit for a nonzero effect code and the high nibble of its parameter
  function automatic logic [5:0] effect_feature(input logic [4:0] code,
                                                input logic [3:0] hi);
    logic [5:0] bit_idx;
    bit_idx = 6'(FEAT_UNKNOWN);
    if (code >= 5'd1 && code <= 5'd13) begin
      bit_idx = 6'd8 + {1'b0, code};
    end else if (code == FX_EXT) begin
      bit_idx = EXT_FEATURE[hi];
    end else if (code >= 5'd15 && code <= 5'd20) begin
      bit_idx = 6'd20 + {1'b0, code};
    end else if (code == FX_NIBBLE_SEL) begin
      if (hi == 4'h0) begin
        bit_idx = 6'd41;
      end else if (hi == 4'h8) begin
        bit_idx = 6'd42;
      end else if (hi == 4'hD) begin
        bit_idx = 6'd43;
      end else begin
        bit_idx = 6'd44;
      end
    end else if (code == FX_LAST) begin
      bit_idx = 6'd45;
    end
    return bit_idx;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ppsd_in_if.sv
// Input byte channel of the decoder.
`default_nettype none
interface ppsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/ppsd_out_if.sv
// Result channel of the decoder.
`default_nettype none
interface ppsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [8:0]  row_index;
  logic [4:0]  track_index;
  logic [7:0]  note_value;
  logic [7:0]  instrument_value;
  logic [1:0]  effect_slot;
  logic [4:0]  effect_code;
  logic [7:0]  effect_param;
  logic [1:0]  status_code;
  logic [49:0] feature_mask;
  logic        last_result;

  modport source (output valid, result_kind, row_index, track_index, note_value,
                  instrument_value, effect_slot, effect_code, effect_param,
                  status_code, feature_mask, last_result, input ready);
  modport sink (input valid, result_kind, row_index, track_index, note_value,
                instrument_value, effect_slot, effect_code, effect_param,
                status_code, feature_mask, last_result, output ready);
endinterface
`default_nettype wire

// File: rtl/packed_pattern_stream_decoder_core.sv
// Top level of the packed pattern stream decoder.
//
// Usage:
//   in_bus  : one beat per stream byte, with a command (data byte, new file,
//             end of data). in_bus.ready is high while the group queue has room.
//   out_bus : note, effect, pattern-done and error results; last_result marks
//             the final result caused by one input beat.
// Path: a result passes through a queue entry, then the output register,
//   before it appears on out_bus.
// Throughput: one input beat per cycle while each beat causes at most one
//   result and the receiver takes every result; a beat that causes two
//   results sends them in turn through the single output port, one per cycle.
// Reset (rst_n low, synchronous): parser returns to expecting a length byte,
//   feature mask and error halt clear, the queue empties and out_bus.valid
//   drops. A new-file command does the same to the parser state only.
// Receiver stall: a result holds on out_bus until taken; the two-group queue
//   fills behind it and in_bus.ready drops once the queue is full.
// After an error, data and end-of-data beats are taken but give no result.
`default_nettype none
module packed_pattern_stream_decoder_core import ppsd_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  ppsd_in_if.sink    in_bus,
  ppsd_out_if.source out_bus
);

  logic      q_push, q_pop, q_empty, q_full;
  ppsd_grp_t q_grp, q_head;

  // Parse bytes and classify them into result groups
  ppsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_grp  (q_grp)
  );

  // Decouple parser from output stalls
  ppsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .grp_in (q_grp),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  // Drain groups one result beat at a time
  ppsd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full group queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("pop from empty group queue");

  // A two-result group always opens with a note or effect event
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_grp.two) |->
      (q_grp.r0.kind == KIND_NOTE || q_grp.r0.kind == KIND_EFFECT))
    else $error("two-result group without leading event");

endmodule
`default_nettype wire

// File: rtl/ppsd_front.sv
// Front end: parses one stream byte per beat and builds its result group.
`default_nettype none
module ppsd_front import ppsd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  ppsd_in_if.sink   in_bus,
  input  wire       q_full,
  output logic      q_push,
  output ppsd_grp_t q_grp
);

  localparam logic [2:0] PH_LEN_LO = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_CHAN   = 3'd2;
  localparam logic [2:0] PH_NOTE   = 3'd3;
  localparam logic [2:0] PH_INST   = 3'd4;
  localparam logic [2:0] PH_FX     = 3'd5;
  localparam logic [2:0] PH_PARAM  = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [15:0]       size_r, size_nxt;
  logic [16:0]       bp_r, bp_nxt;
  logic [8:0]        rows_r, rows_nxt;
  logic [4:0]        trk_r, trk_nxt;
  logic [7:0]        note_r, note_nxt;
  logic [7:0]        fxb_r, fxb_nxt;
  logic [2:0]        nfx_r, nfx_nxt;
  logic              want_r, want_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              halt_r, halt_nxt;

  logic      acc;
  logic [7:0] b;
  logic      have0, have1, eoe, err2, err3;
  ppsd_res_t res0, res1;

  assign in_bus.ready = !q_full;
  assign acc          = in_bus.valid && !q_full;
  assign b            = in_bus.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    len_lo_nxt = len_lo_r;
    size_nxt   = size_r;
    bp_nxt     = bp_r;
    rows_nxt   = rows_r;
    trk_nxt    = trk_r;
    note_nxt   = note_r;
    fxb_nxt    = fxb_r;
    nfx_nxt    = nfx_r;
    want_nxt   = want_r;
    mask_nxt   = mask_r;
    halt_nxt   = halt_r;
    have0      = 1'b0;
    have1      = 1'b0;
    eoe        = 1'b0;
    err2       = 1'b0;
    err3       = 1'b0;
    res0       = '0;
    res1       = '0;

    // First stage: the byte itself, with at most one event
    if (acc) begin
      unique case (in_bus.cmd)
        CMD_NEW: begin
          phase_nxt  = PH_LEN_LO;
          len_lo_nxt = '0;
          size_nxt   = '0;
          bp_nxt     = '0;
          rows_nxt   = '0;
          trk_nxt    = '0;
          note_nxt   = '0;
          fxb_nxt    = '0;
          nfx_nxt    = '0;
          want_nxt   = 1'b0;
          mask_nxt   = '0;
          halt_nxt   = 1'b0;
        end
        CMD_END: begin
          if (!halt_r && phase_r != PH_LEN_LO) begin
            err3 = 1'b1;
          end
        end
        CMD_DATA: begin
          if (!halt_r) begin
            unique case (phase_r)
              PH_LEN_LO: begin
                len_lo_nxt = b;
                phase_nxt  = PH_LEN_HI;
              end
              PH_LEN_HI: begin
                size_nxt = {b, len_lo_r} - 16'd2;
                bp_nxt   = '0;
                rows_nxt = '0;
                eoe      = 1'b1;
              end
              PH_CHAN: begin
                bp_nxt = bp_r + 17'd1;
                if (b == 8'd0) begin
                  rows_nxt = rows_r + 9'd1;
                  eoe      = 1'b1;
                end else begin
                  trk_nxt  = b[4:0];
                  nfx_nxt  = '0;
                  want_nxt = b[6];
                  if (b[5]) begin
                    phase_nxt = PH_NOTE;
                  end else if (b[6]) begin
                    phase_nxt = PH_FX;
                  end else begin
                    eoe = 1'b1;
                  end
                end
              end
              PH_NOTE: begin
                bp_nxt    = bp_r + 17'd1;
                note_nxt  = b;
                phase_nxt = PH_INST;
              end
              PH_INST: begin
                bp_nxt = bp_r + 17'd1;
                if (note_r == 8'd0) mask_nxt[FEAT_NO_NOTE] = 1'b1;
                if (b == 8'd0)      mask_nxt[FEAT_NO_INST] = 1'b1;
                have0       = 1'b1;
                res0.kind   = KIND_NOTE;
                res0.row    = rows_r;
                res0.track  = trk_r;
                res0.note   = note_r;
                res0.inst   = b;
                res0.mask   = mask_nxt;
                if (want_r) begin
                  phase_nxt = PH_FX;
                end else begin
                  eoe = 1'b1;
                end
              end
              PH_FX: begin
                bp_nxt    = bp_r + 17'd1;
                fxb_nxt   = b;
                phase_nxt = PH_PARAM;
              end
              PH_PARAM: begin
                bp_nxt = bp_r + 17'd1;
                if (fxb_r[7:6] == 2'd2) mask_nxt[FEAT_SLOT3] = 1'b1;
                if (fxb_r[7:6] == 2'd3) mask_nxt[FEAT_SLOT4] = 1'b1;
                if (fxb_r[4:0] != 5'd0) begin
                  mask_nxt[effect_feature(fxb_r[4:0], b[7:4])] = 1'b1;
                end
                have0       = 1'b1;
                res0.kind   = KIND_EFFECT;
                res0.row    = rows_r;
                res0.track  = trk_r;
                res0.slot   = fxb_r[7:6];
                res0.code   = fxb_r[4:0];
                res0.param  = b;
                res0.mask   = mask_nxt;
                nfx_nxt     = nfx_r + 3'd1;
                if (fxb_r[5]) begin
                  if (nfx_nxt >= MAX_EFFECTS) begin
                    err2 = 1'b1;
                  end else begin
                    phase_nxt = PH_FX;
                  end
                end else begin
                  eoe = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // Second stage: an error, or the end-of-entry check
    if (err2 || err3) begin
      have1       = 1'b1;
      halt_nxt    = 1'b1;
      res1.kind   = KIND_ERROR;
      res1.row    = rows_nxt;
      res1.track  = trk_nxt;
      res1.status = err2 ? STAT_MANY_FX : STAT_TRUNCATED;
      res1.mask   = mask_nxt;
    end else if (eoe) begin
      phase_nxt = PH_CHAN;
      if (!(bp_nxt < {1'b0, size_nxt} && rows_nxt < MAX_ROWS)) begin
        have1 = 1'b1;
        if (bp_nxt != {1'b0, size_nxt}) begin
          halt_nxt    = 1'b1;
          res1.kind   = KIND_ERROR;
          res1.row    = rows_nxt;
          res1.track  = trk_nxt;
          res1.status = STAT_BAD_LEN;
          res1.mask   = mask_nxt;
        end else begin
          if (rows_nxt > ROWS_WIDE) mask_nxt[FEAT_ROWS64]  = 1'b1;
          if (rows_nxt > MAX_ROWS)  mask_nxt[FEAT_ROWS256] = 1'b1;
          res1.kind = KIND_DONE;
          res1.row  = rows_nxt;
          res1.mask = mask_nxt;
          phase_nxt = PH_LEN_LO;
          bp_nxt    = '0;
          rows_nxt  = '0;
        end
      end
    end

    // Pack the group; the last result of the beat carries the flag
    q_push       = have0 || have1;
    q_grp.two    = have0 && have1;
    q_grp.r0     = have0 ? res0 : res1;
    q_grp.r0.last = !(have0 && have1);
    q_grp.r1      = res1;
    q_grp.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN_LO;
      len_lo_r <= '0;
      size_r   <= '0;
      bp_r     <= '0;
      rows_r   <= '0;
      trk_r    <= '0;
      note_r   <= '0;
      fxb_r    <= '0;
      nfx_r    <= '0;
      want_r   <= 1'b0;
      mask_r   <= '0;
      halt_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_lo_r <= len_lo_nxt;
      size_r   <= size_nxt;
      bp_r     <= bp_nxt;
      rows_r   <= rows_nxt;
      trk_r    <= trk_nxt;
      note_r   <= note_nxt;
      fxb_r    <= fxb_nxt;
      nfx_r    <= nfx_nxt;
      want_r   <= want_nxt;
      mask_r   <= mask_nxt;
      halt_r   <= halt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppsd_queue.sv
// Short queue of result groups between the parser and the output stage.
`default_nettype none
module ppsd_queue import ppsd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       push,
  input  ppsd_grp_t grp_in,
  input  wire       pop,
  output ppsd_grp_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = $clog2(QDEPTH);

  ppsd_grp_t       q_r [QDEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign head  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (PW+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= grp_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PW'(1);
      if (pop)  rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppsd_back.sv
// Back end: unpacks result groups into single result beats behind an output register.
`default_nettype none
module ppsd_back import ppsd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  ppsd_grp_t head,
  input  wire       q_empty,
  output logic      q_pop,
  ppsd_out_if.source out_bus
);

  logic      sub_r, sub_nxt;
  logic      vld_r;
  ppsd_res_t out_r;
  logic      load;

  assign load    = !q_empty && (!vld_r || out_bus.ready);
  assign q_pop   = load && (sub_r || !head.two);
  assign sub_nxt = load ? (!sub_r && head.two) : sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= sub_r ? head.r1 : head.r0;
  end

  assign out_bus.valid            = vld_r;
  assign out_bus.result_kind      = out_r.kind;
  assign out_bus.row_index        = out_r.row;
  assign out_bus.track_index      = out_r.track;
  assign out_bus.note_value       = out_r.note;
  assign out_bus.instrument_value = out_r.inst;
  assign out_bus.effect_slot      = out_r.slot;
  assign out_bus.effect_code      = out_r.code;
  assign out_bus.effect_param     = out_r.param;
  assign out_bus.status_code      = out_r.status;
  assign out_bus.feature_mask     = out_r.mask;
  assign out_bus.last_result      = out_r.last;

endmodule
`default_nettype wire
